@@ rtl/bpc_pkg.sv @@
// Shared types and constants for the button press classifier.
`default_nettype none
package bpc_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned PAUSE_W   = 5;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  // pause bit positions
  localparam int unsigned PB_CORE       = 0;
  localparam int unsigned PB_SHOT_COUNT = 1;
  localparam int unsigned PB_HOLD_COUNT = 2;
  localparam int unsigned PB_SHOT_PULSE = 3;
  localparam int unsigned PB_HOLD_PULSE = 4;

  localparam logic [TIME_W-1:0]  SHOT_MIN_RST    = TIME_W'(50);
  localparam logic [TIME_W-1:0]  HOLD_MIN_RST    = TIME_W'(1000);
  localparam logic [TIME_W-1:0]  HOLD_REPEAT_RST = TIME_W'(500);
  localparam logic [PAUSE_W-1:0] PAUSE_RST       = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHOT_MIN    = 8'd0,
    REG_HOLD_MIN    = 8'd1,
    REG_HOLD_REPEAT = 8'd2,
    REG_PAUSE       = 8'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    LATCH_NONE = 2'd0,
    LATCH_SHOT = 2'd1,
    LATCH_HOLD = 2'd2
  } latch_t;

  typedef struct packed {
    logic [TIME_W-1:0]  shot_min;
    logic [TIME_W-1:0]  hold_min;
    logic [TIME_W-1:0]  hold_repeat;
    logic [PAUSE_W-1:0] pause;
  } cfg_t;

  typedef struct packed {
    logic              level;
    logic [TIME_W-1:0] now_ms;
    logic              poll_shot;
    logic              poll_hold;
    logic              clear_shots;
    logic              clear_holds;
  } in_item_t;

  typedef struct packed {
    logic             shot_pulse;
    logic             hold_pulse;
    logic             shot_seen;
    logic             hold_seen;
    logic [CNT_W-1:0] shot_total;
    logic [CNT_W-1:0] hold_total;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/bpc_cfg_regs.sv @@
// Configuration register file for the button press classifier.
`default_nettype none
module bpc_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [bpc_pkg::CFG_DAT_W-1:0] wr_data,
  output bpc_pkg::cfg_t                      cfg
);
  import bpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_SHOT_MIN:    cfg_nxt.shot_min    = wr_data[TIME_W-1:0];
        REG_HOLD_MIN:    cfg_nxt.hold_min    = wr_data[TIME_W-1:0];
        REG_HOLD_REPEAT: cfg_nxt.hold_repeat = wr_data[TIME_W-1:0];
        REG_PAUSE:       cfg_nxt.pause       = wr_data[PAUSE_W-1:0];
        default:         cfg_nxt = cfg_r;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shot_min    <= SHOT_MIN_RST;
      cfg_r.hold_min    <= HOLD_MIN_RST;
      cfg_r.hold_repeat <= HOLD_REPEAT_RST;
      cfg_r.pause       <= PAUSE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ rtl/bpc_step.sv @@
// Press timing state and the per-item classification logic.
`default_nettype none
module bpc_step (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire bpc_pkg::in_item_t item,
  input  wire bpc_pkg::cfg_t    cfg,
  output bpc_pkg::result_t res
);
  import bpc_pkg::*;

  logic [TIME_W-1:0] press_start_r, press_start_nxt;
  logic              press_valid_r, press_valid_nxt;
  logic [TIME_W-1:0] last_notify_r, last_notify_nxt;
  latch_t            latch_r, latch_nxt;
  logic [CNT_W-1:0]  shots_r, shots_nxt;
  logic [CNT_W-1:0]  holds_r, holds_nxt;

  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] since_notify;
  logic              long_enough;
  logic              is_shot;

  assign held         = item.now_ms - press_start_r;
  assign since_notify = item.now_ms - last_notify_r;
  assign long_enough  = (held >= cfg.hold_min);
  assign is_shot      = (held >= cfg.shot_min) && !long_enough;

  always_comb begin
    press_start_nxt = press_start_r;
    press_valid_nxt = press_valid_r;
    last_notify_nxt = last_notify_r;
    latch_nxt       = latch_r;
    shots_nxt       = shots_r;
    holds_nxt       = holds_r;
    res             = '0;

    if (!cfg.pause[PB_CORE]) begin
      if (item.level && !press_valid_r) begin
        press_start_nxt = item.now_ms;
        press_valid_nxt = 1'b1;
      end else if (item.level) begin
        if (long_enough && (since_notify >= cfg.hold_repeat)) begin
          last_notify_nxt = item.now_ms;
          res.hold_pulse  = !cfg.pause[PB_HOLD_PULSE];
          latch_nxt       = LATCH_HOLD;
        end
      end else if (press_valid_r) begin
        if (is_shot) begin
          if (!cfg.pause[PB_SHOT_COUNT]) shots_nxt = shots_r + CNT_W'(1);
          res.shot_pulse = !cfg.pause[PB_SHOT_PULSE];
          latch_nxt      = LATCH_SHOT;
        end
        if (long_enough && !cfg.pause[PB_HOLD_COUNT]) holds_nxt = holds_r + CNT_W'(1);
        press_start_nxt = '0;
        press_valid_nxt = 1'b0;
      end
    end

    // clears win over this item's increments
    if (item.clear_shots) shots_nxt = '0;
    if (item.clear_holds) holds_nxt = '0;

    // polls see a latch set by this same item
    if (item.poll_shot && latch_nxt == LATCH_SHOT) begin
      res.shot_seen = 1'b1;
      latch_nxt     = LATCH_NONE;
    end
    if (item.poll_hold && latch_nxt == LATCH_HOLD) begin
      res.hold_seen = 1'b1;
      latch_nxt     = LATCH_NONE;
    end

    res.shot_total = shots_nxt;
    res.hold_total = holds_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_start_r <= '0;
      press_valid_r <= 1'b0;
      last_notify_r <= '0;
      latch_r       <= LATCH_NONE;
      shots_r       <= '0;
      holds_r       <= '0;
    end else if (step_en) begin
      press_start_r <= press_start_nxt;
      press_valid_r <= press_valid_nxt;
      last_notify_r <= last_notify_nxt;
      latch_r       <= latch_nxt;
      shots_r       <= shots_nxt;
      holds_r       <= holds_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/button_press_classifier.sv @@
// Top level of the button press classifier: input stage, step logic, result stage.
// An item's result is computed by the step logic and held in the result register.
// Throughput: one item per cycle unless out_ready stalls; the step logic is a 32-bit
// subtract and compare per threshold between the input and the result register.
// Reset (rst_n low, synchronous): both stages empty, press state, latch and counts
// cleared, registers back to 50 / 1000 / 500 ms and no pause bits.
`default_nettype none
module button_press_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input items
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          in_level,
  input  wire logic [bpc_pkg::TIME_W-1:0]    in_now_ms,
  input  wire logic                          in_poll_shot,
  input  wire logic                          in_poll_hold,
  input  wire logic                          in_clear_shots,
  input  wire logic                          in_clear_holds,
  // result items
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic                          out_shot_pulse,
  output      logic                          out_hold_pulse,
  output      logic                          out_shot_seen,
  output      logic                          out_hold_seen,
  output      logic [bpc_pkg::CNT_W-1:0]     out_shot_total,
  output      logic [bpc_pkg::CNT_W-1:0]     out_hold_total,
  // configuration writes
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bpc_pkg::CFG_DAT_W-1:0] cfg_data
);
  import bpc_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  in_item_t s1_item_r;
  logic     s1_valid_r;
  logic     advance;
  result_t  step_res;
  result_t  out_res_r;
  logic     out_valid_r;

  // config is always writable; the user must write only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  bpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign in_item.level       = in_level;
  assign in_item.now_ms      = in_now_ms;
  assign in_item.poll_shot   = in_poll_shot;
  assign in_item.poll_hold   = in_poll_hold;
  assign in_item.clear_shots = in_clear_shots;
  assign in_item.clear_holds = in_clear_holds;

  // Input stage moves on whenever the result register is free or being drained.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  // State commits only when the item's result is captured.
  bpc_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_shot_pulse = out_res_r.shot_pulse;
  assign out_hold_pulse = out_res_r.hold_pulse;
  assign out_shot_seen  = out_res_r.shot_seen;
  assign out_hold_seen  = out_res_r.hold_seen;
  assign out_shot_total = out_res_r.shot_total;
  assign out_hold_total = out_res_r.hold_total;

`ifndef NO_ASSERTIONS
  // A single latch can answer only one poll per item.
  a_one_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.shot_seen && out_res_r.hold_seen))
    else $error("shot and hold both seen in one item");

  // A press cannot give both a shot pulse and a hold pulse in one item.
  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.shot_pulse && out_res_r.hold_pulse))
    else $error("shot and hold pulse in one item");

  // An empty input stage always takes an item.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stage empty but not ready");

  // A captured result shows up as valid on the next cycle.
  a_adv_valid: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result lost after advance");
`endif

endmodule
`default_nettype wire
